### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// An antecedent that implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/ycmr_pkg.sv
// ----------------------------------------------------------------------------
// ycmr_pkg
// Types, register indexes and fixed-point coefficients of the colour round trip.
// ----------------------------------------------------------------------------
package ycmr_pkg;

	// Fractional bits of every coefficient.
	localparam int COEF_FRAC_BITS = 16;

	localparam int COEF_W = COEF_FRAC_BITS + 3;
	localparam int OPND_W = 9;
	localparam int PROD_W = COEF_W + OPND_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int RND_W  = SUM_W - COEF_FRAC_BITS;

	// Register stages of the datapath.
	localparam int NSTG = 6;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEEP_LUMA        = 2'd0,
		REG_KEEP_BLUE_CHROMA = 2'd1,
		REG_KEEP_RED_CHROMA  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] blue_chroma;
		logic [7:0] red_chroma;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	// Quantise a coefficient given in units of 1/10000, rounding half away from zero.
	function automatic int coef(input int n);
		longint m;
		longint q;
		m = (n < 0) ? -longint'(n) : longint'(n);
		q = ((m << COEF_FRAC_BITS) + 64'sd5000) / 10000;
		return (n < 0) ? -int'(q) : int'(q);
	endfunction

	typedef logic signed [COEF_W-1:0] coef_t;

	localparam coef_t C_Y_R  = COEF_W'(coef(2990));
	localparam coef_t C_Y_G  = COEF_W'(coef(5870));
	localparam coef_t C_Y_B  = COEF_W'(coef(1140));
	localparam coef_t C_CB_R = COEF_W'(coef(-1687));
	localparam coef_t C_CB_G = COEF_W'(coef(-3313));
	localparam coef_t C_CB_B = COEF_W'(coef(5000));
	localparam coef_t C_CR_R = COEF_W'(coef(5000));
	localparam coef_t C_CR_G = COEF_W'(coef(-4187));
	localparam coef_t C_CR_B = COEF_W'(coef(-813));
	localparam coef_t C_R_CR = COEF_W'(coef(14020));
	localparam coef_t C_G_CB = COEF_W'(coef(-3441));
	localparam coef_t C_G_CR = COEF_W'(coef(-7141));
	localparam coef_t C_B_CB = COEF_W'(coef(17720));

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// Rounding half away from zero becomes a single add with a sign-chosen bias
	// followed by an arithmetic shift; the chroma offset is folded into it.
	localparam sum_t POS_BIAS = SUM_W'(2 ** (COEF_FRAC_BITS - 1));
	localparam sum_t NEG_BIAS = SUM_W'(2 ** COEF_FRAC_BITS - 1 - 2 ** (COEF_FRAC_BITS - 1));
	localparam sum_t OFS_128  = SUM_W'(128) <<< COEF_FRAC_BITS;
	localparam sum_t SUM_ZERO = SUM_W'(0);

	localparam logic signed [RND_W-1:0] RND_ZERO = RND_W'(0);
	localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'(255);

	localparam logic [7:0] NEUTRAL = 8'd128;

	function automatic prod_t mul(input logic signed [OPND_W-1:0] a, input coef_t c);
		prod_t pa;
		prod_t pc;
		pa = PROD_W'(a);
		pc = PROD_W'(c);
		return pa * pc;
	endfunction

	function automatic sum_t sum3(input prod_t a, input prod_t b, input prod_t c);
		return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
	endfunction

	function automatic logic [7:0] round_clamp(input sum_t s, input logic add_ofs);
		sum_t t;
		logic signed [RND_W-1:0] r;
		t = s + (s[SUM_W-1] ? NEG_BIAS : POS_BIAS) + (add_ofs ? OFS_128 : SUM_ZERO);
		r = $signed(t[SUM_W-1:COEF_FRAC_BITS]);
		if (r < RND_ZERO) begin
			return 8'd0;
		end else if (r > RND_MAX) begin
			return 8'd255;
		end
		return r[7:0];
	endfunction

endpackage

### src/ycbcr_channel_mask_roundtrip.sv
// ----------------------------------------------------------------------------
// ycbcr_channel_mask_roundtrip
// Full-range BT.601 RGB to YCbCr and back, with a per-component mask.
//
// The pixel channel (pixel_valid, pixel_stall, pixel) takes one 8-bit RGB
// request; the result channel (result_valid, result_stall, result) returns the
// masked YCbCr and the RGB rebuilt from it. A request is taken when valid is
// high and stall is low.
// The datapath is a six-stage pipeline: forward products, forward sums,
// rounding with clamping and masking, inverse products, inverse sums, and
// rounding into the output register. One pixel is taken in every cycle
// unless the pipeline stalls; the multiplier stages set the clock.
// When the receiver stalls, each full stage holds whilst its successor cannot
// load, so empty stages keep filling and nothing is lost or repeated.
// The configuration port writes keep_luma, keep_blue_chroma and
// keep_red_chroma (bit 0 of cfg_data); it should be written only when the
// pipeline is empty. Reset empties the pipeline and sets all three bits.
// ----------------------------------------------------------------------------
module ycbcr_channel_mask_roundtrip (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ycmr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic                                cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  ycmr_pkg::pix_in_t                   pixel,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ycmr_pkg::pix_out_t                  result
);

	logic keep_luma_q;
	logic keep_blue_chroma_q;
	logic keep_red_chroma_q;

	// Valid bit and load enable per stage.
	logic [ycmr_pkg::NSTG:1] vld;
	logic [ycmr_pkg::NSTG:1] en;

	ycmr_pkg::prod_t fp_s1 [9];
	ycmr_pkg::sum_t  fs_s2 [3];
	logic [7:0]      ycc_s3 [3];
	logic [7:0]      ycc_s4 [3];
	ycmr_pkg::prod_t ip_s4 [4];
	logic [7:0]      ycc_s5 [3];
	ycmr_pkg::sum_t  is_s5 [3];
	ycmr_pkg::pix_out_t res_s6;

	logic signed [ycmr_pkg::OPND_W-1:0] r_op;
	logic signed [ycmr_pkg::OPND_W-1:0] g_op;
	logic signed [ycmr_pkg::OPND_W-1:0] b_op;
	logic signed [ycmr_pkg::OPND_W-1:0] cb_op;
	logic signed [ycmr_pkg::OPND_W-1:0] cr_op;
	ycmr_pkg::sum_t  y_term;
	logic [7:0]      ycc_nx [3];
	logic [2:0]      keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_luma_q        <= 1'b1;
			keep_blue_chroma_q <= 1'b1;
			keep_red_chroma_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				ycmr_pkg::REG_KEEP_LUMA:        keep_luma_q        <= cfg_data;
				ycmr_pkg::REG_KEEP_BLUE_CHROMA: keep_blue_chroma_q <= cfg_data;
				ycmr_pkg::REG_KEEP_RED_CHROMA:  keep_red_chroma_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or its contents move on this cycle.
	always_comb begin
		en[ycmr_pkg::NSTG] = !vld[ycmr_pkg::NSTG] || !result_stall;
		for (int k = ycmr_pkg::NSTG - 1; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign pixel_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) begin
				vld[1] <= pixel_valid;
			end
			for (int k = 2; k <= ycmr_pkg::NSTG; k++) begin
				if (en[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	assign r_op = $signed({1'b0, pixel.red_in});
	assign g_op = $signed({1'b0, pixel.green_in});
	assign b_op = $signed({1'b0, pixel.blue_in});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fp_s1[0] <= ycmr_pkg::mul(r_op, ycmr_pkg::C_Y_R);
			fp_s1[1] <= ycmr_pkg::mul(g_op, ycmr_pkg::C_Y_G);
			fp_s1[2] <= ycmr_pkg::mul(b_op, ycmr_pkg::C_Y_B);
			fp_s1[3] <= ycmr_pkg::mul(r_op, ycmr_pkg::C_CB_R);
			fp_s1[4] <= ycmr_pkg::mul(g_op, ycmr_pkg::C_CB_G);
			fp_s1[5] <= ycmr_pkg::mul(b_op, ycmr_pkg::C_CB_B);
			fp_s1[6] <= ycmr_pkg::mul(r_op, ycmr_pkg::C_CR_R);
			fp_s1[7] <= ycmr_pkg::mul(g_op, ycmr_pkg::C_CR_G);
			fp_s1[8] <= ycmr_pkg::mul(b_op, ycmr_pkg::C_CR_B);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				fs_s2[i] <= ycmr_pkg::sum3(fp_s1[3*i], fp_s1[3*i+1], fp_s1[3*i+2]);
			end
		end
	end

	assign keep = {keep_red_chroma_q, keep_blue_chroma_q, keep_luma_q};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ycc_nx[i] = keep[i] ? ycmr_pkg::round_clamp(fs_s2[i], (i != 0))
			                    : ycmr_pkg::NEUTRAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ycc_s3 <= ycc_nx;
		end
	end

	// Subtracting 128 from an 8-bit chroma value is an inversion of its top bit.
	assign cb_op = $signed({~ycc_s3[1][7], ~ycc_s3[1][7], ycc_s3[1][6:0]});
	assign cr_op = $signed({~ycc_s3[2][7], ~ycc_s3[2][7], ycc_s3[2][6:0]});

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ycc_s4   <= ycc_s3;
			ip_s4[0] <= ycmr_pkg::mul(cr_op, ycmr_pkg::C_R_CR);
			ip_s4[1] <= ycmr_pkg::mul(cb_op, ycmr_pkg::C_G_CB);
			ip_s4[2] <= ycmr_pkg::mul(cr_op, ycmr_pkg::C_G_CR);
			ip_s4[3] <= ycmr_pkg::mul(cb_op, ycmr_pkg::C_B_CB);
		end
	end

	// Luma has a unit coefficient, so its term is a plain shift.
	assign y_term = ycmr_pkg::SUM_W'($signed({1'b0, ycc_s4[0]})) <<< ycmr_pkg::COEF_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ycc_s5   <= ycc_s4;
			is_s5[0] <= y_term + ycmr_pkg::SUM_W'(ip_s4[0]);
			is_s5[1] <= y_term + ycmr_pkg::SUM_W'(ip_s4[1]) + ycmr_pkg::SUM_W'(ip_s4[2]);
			is_s5[2] <= y_term + ycmr_pkg::SUM_W'(ip_s4[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			res_s6.luma        <= ycc_s5[0];
			res_s6.blue_chroma <= ycc_s5[1];
			res_s6.red_chroma  <= ycc_s5[2];
			res_s6.red_out     <= ycmr_pkg::round_clamp(is_s5[0], 1'b0);
			res_s6.green_out   <= ycmr_pkg::round_clamp(is_s5[1], 1'b0);
			res_s6.blue_out    <= ycmr_pkg::round_clamp(is_s5[2], 1'b0);
		end
	end

	assign result_valid = vld[ycmr_pkg::NSTG];
	assign result       = res_s6;

endmodule

### src/ycmr_checker.sv
// ----------------------------------------------------------------------------
// ycmr_checker
// Port-level checks of the colour round trip, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ycmr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	input  logic                           pixel_stall,
	input  ycmr_pkg::pix_in_t              pixel,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  ycmr_pkg::pix_out_t             result
);

	logic cb_neutral;
	logic cr_neutral;
	logic chroma_neutral;
	logic red_is_luma;
	logic grey_is_luma;
	logic pixel_held;
	logic result_held;

	assign cb_neutral     = result.blue_chroma == ycmr_pkg::NEUTRAL;
	assign cr_neutral     = result.red_chroma == ycmr_pkg::NEUTRAL;
	assign chroma_neutral = cb_neutral && cr_neutral;
	assign red_is_luma    = result.red_out == result.luma;
	assign grey_is_luma   = result.green_out == result.luma && result.blue_out == result.luma;
	assign pixel_held     = pixel_valid && pixel_stall;
	assign result_held    = result_valid && result_stall;

	// A stalled pixel request stays offered and unchanged.
	`ASSERT_NEXT(a_pixel_hold, clk, arst_n, pixel_held, pixel_valid && $stable(pixel))

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_held, result_valid && $stable(result))

	// With nothing waiting at the output, the pipeline always has room.
	`ASSERT_IMPLIES(a_empty_no_stall, clk, arst_n, !result_valid, !pixel_stall)

	// Neutral red chroma leaves red equal to luma.
	`ASSERT_IMPLIES(a_red_from_luma, clk, arst_n, result_valid && cr_neutral, red_is_luma)

	// Neutral chroma on both components gives a grey pixel equal to luma.
	`ASSERT_IMPLIES(a_grey_from_luma, clk, arst_n, result_valid && chroma_neutral, grey_is_luma)

endmodule

bind ycbcr_channel_mask_roundtrip ycmr_checker u_checker (.*);
